// File: rtl/text_console_char_writer_top_defines.svh
// assertion macros for the console writer checker
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_DEFINES_SVH

// checked at every edge, reset included
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked only out of reset
`define TCW_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int SEL_W    = 2;
  localparam int TCOL_W   = 7;
  localparam int TROW_W   = 5;
  localparam int POS_W    = 11;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_LAST_ROW    = 24;
  localparam int DEF_TAB_WIDTH   = 8;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] RST_COLOR_NORMAL  = 8'd7;
  localparam logic [ATTR_W-1:0] RST_COLOR_KERNEL  = 8'd4;
  localparam logic [ATTR_W-1:0] RST_COLOR_PROGRAM = 8'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_NORMAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_KERNEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_PROGRAM = 2'd2;

  localparam logic [SEL_W-1:0] SEL_KERNEL  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_PROGRAM = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_PRINT = 2'd0,
    OP_CLEAR = 2'd1,
    OP_MOVE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic wr;
    logic scroll;
    logic clr;
    logic rd;
  } cmd_ctl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SCROLL,
    BK_FILL,
    BK_CLEAR
  } back_state_t;

endpackage

// File: rtl/text_console_char_writer_top.sv
`timescale 1ns / 1ps
// channel  | handshake        | payload
// ---------+------------------+-------------------------------------------------
// in       | in_push, in_full | in_op, in_char_code, in_attr_select,
//          |                  | in_target_col, in_target_row
// out      | out_pop, out_empty | out_cursor_pos, out_cell_char, out_cell_attr
// cfg      | cfg_we           | cfg_index, cfg_data
//
// a request enters the command queue in the cycle it is accepted; the executor
// then takes requests one at a time, and a scrolling line end or a clear is
// paced by the single write port of the cell memory.
// after reset the cell memory is swept to zero with in_full held high.
// the queue keeps accepting while a result waits or a scroll runs.
module text_console_char_writer_top #(
  parameter int SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
  parameter int LAST_ROW    = tcw_pkg::DEF_LAST_ROW,
  parameter int TAB_WIDTH   = tcw_pkg::DEF_TAB_WIDTH,
  parameter int QUEUE_DEPTH = tcw_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [tcw_pkg::OP_W-1:0]       in_op,
  input  logic [tcw_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [tcw_pkg::SEL_W-1:0]      in_attr_select,
  input  logic [tcw_pkg::TCOL_W-1:0]     in_target_col,
  input  logic [tcw_pkg::TROW_W-1:0]     in_target_row,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [tcw_pkg::POS_W-1:0]      out_cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0]     out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]     out_cell_attr,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = SCREEN_COLS * (LAST_ROW + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int QW    = $bits(cmd_ctl_t) + AW + CELL_W + POS_W;

  logic              accept, q_full, q_empty, q_pop, init_busy;
  cmd_ctl_t          f_ctl, q_ctl;
  logic [AW-1:0]     f_addr, q_addr;
  logic [CELL_W-1:0] f_data, q_data;
  logic [POS_W-1:0]  f_pos, q_pos;
  logic [QW-1:0]     q_dout;

  assign in_full = q_full || init_busy;
  assign accept  = in_push && !in_full;

  tcw_front #(
    .SCREEN_COLS (SCREEN_COLS),
    .LAST_ROW    (LAST_ROW),
    .TAB_WIDTH   (TAB_WIDTH),
    .AW          (AW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .op          (in_op),
    .char_code   (in_char_code),
    .attr_select (in_attr_select),
    .target_col  (in_target_col),
    .target_row  (in_target_row),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_ctl     (f_ctl),
    .cmd_addr    (f_addr),
    .cmd_data    (f_data),
    .cmd_pos     (f_pos)
  );

  tcw_queue #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   ({f_ctl, f_addr, f_data, f_pos}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {q_ctl, q_addr, q_data, q_pos} = q_dout;

  tcw_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .LAST_ROW    (LAST_ROW),
    .AW          (AW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_ctl          (q_ctl),
    .q_addr         (q_addr),
    .q_data         (q_data),
    .q_pos          (q_pos),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .init_busy      (init_busy)
  );

endmodule

// File: rtl/tcw_queue.sv
`timescale 1ns / 1ps
module tcw_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: rtl/tcw_front.sv
`timescale 1ns / 1ps
module tcw_front #(
  parameter int SCREEN_COLS = 80,
  parameter int LAST_ROW    = 24,
  parameter int TAB_WIDTH   = 8,
  parameter int AW          = 11
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [tcw_pkg::OP_W-1:0]       op,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::SEL_W-1:0]      attr_select,
  input  logic [tcw_pkg::TCOL_W-1:0]     target_col,
  input  logic [tcw_pkg::TROW_W-1:0]     target_row,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data,
  output tcw_pkg::cmd_ctl_t              cmd_ctl,
  output logic [AW-1:0]                  cmd_addr,
  output logic [tcw_pkg::CELL_W-1:0]     cmd_data,
  output logic [tcw_pkg::POS_W-1:0]      cmd_pos
);
  import tcw_pkg::*;

  localparam int CW = $clog2(SCREEN_COLS);
  localparam int RW = (LAST_ROW > 0) ? $clog2(LAST_ROW + 1) : 1;

  logic [ATTR_W-1:0] color_normal_r, color_kernel_r, color_program_r;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [AW-1:0]     pos_r;

  logic [CW-1:0]     tab_stop [SCREEN_COLS];
  logic              tab_wrap [SCREEN_COLS];

  logic [ATTR_W-1:0] attr;
  logic [CW:0]       col_inc;
  logic [CW-1:0]     tc_c, m_col;
  logic [RW-1:0]     tr_c, m_row;
  logic [AW-1:0]     m_lin;
  logic              nl, bs_wr;

  // next tab stop per column, worked out at elaboration
  for (genvar c = 0; c < SCREEN_COLS; c++) begin : g_tab
    localparam int STOP = (c / TAB_WIDTH + 1) * TAB_WIDTH;
    assign tab_stop[c] = (STOP >= SCREEN_COLS) ? '0 : CW'(STOP);
    assign tab_wrap[c] = (STOP >= SCREEN_COLS);
  end

  always_comb begin
    unique case (attr_select)
      SEL_KERNEL:  attr = color_kernel_r;
      SEL_PROGRAM: attr = color_program_r;
      default:     attr = color_normal_r;
    endcase
  end

  always_comb begin
    if (int'(target_col) > SCREEN_COLS - 1) begin
      tc_c = CW'(SCREEN_COLS - 1);
    end else begin
      tc_c = CW'(target_col);
    end
    if (int'(target_row) > LAST_ROW) begin
      tr_c = RW'(LAST_ROW);
    end else begin
      tr_c = RW'(target_row);
    end
  end

  assign col_inc = {1'b0, col_r} + 1'b1;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    cmd_ctl  = '0;
    cmd_data = {attr, char_code};
    nl       = 1'b0;
    bs_wr    = 1'b0;
    unique case (op_t'(op))
      OP_PRINT: begin
        unique case (char_code)
          CH_TAB: begin
            if (tab_wrap[col_r]) begin
              nl = 1'b1;
            end else begin
              col_nxt = tab_stop[col_r];
            end
          end
          CH_CR: col_nxt = '0;
          CH_LF: nl = 1'b1;
          CH_BS: begin
            if (col_r != '0) begin
              col_nxt    = col_r - 1'b1;
              cmd_ctl.wr = 1'b1;
              bs_wr      = 1'b1;
              cmd_data   = {attr, CH_SPACE};
            end
          end
          default: begin
            cmd_ctl.wr = 1'b1;
            if (col_inc == (CW+1)'(SCREEN_COLS)) begin
              nl = 1'b1;
            end else begin
              col_nxt = col_inc[CW-1:0];
            end
          end
        endcase
        if (nl) begin
          col_nxt = '0;
          if (row_r < RW'(LAST_ROW)) begin
            row_nxt = row_r + 1'b1;
          end else begin
            cmd_ctl.scroll = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        cmd_ctl.clr = 1'b1;
        col_nxt     = '0;
        row_nxt     = '0;
      end
      OP_MOVE: begin
        col_nxt = tc_c;
        row_nxt = tr_c;
      end
      OP_READ: cmd_ctl.rd = 1'b1;
      default: cmd_ctl = '0;
    endcase
  end

  // one shared row * cols multiply: read address or new cursor position
  assign m_row = cmd_ctl.rd ? tr_c : row_nxt;
  assign m_col = cmd_ctl.rd ? tc_c : col_nxt;
  assign m_lin = AW'(int'(m_row) * SCREEN_COLS + int'(m_col));

  always_comb begin
    if (cmd_ctl.rd) begin
      cmd_addr = m_lin;
      cmd_pos  = POS_W'(pos_r);
    end else begin
      cmd_addr = bs_wr ? pos_r - 1'b1 : pos_r;
      cmd_pos  = POS_W'(m_lin);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (!cmd_ctl.rd) begin
        pos_r <= m_lin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_normal_r  <= RST_COLOR_NORMAL;
      color_kernel_r  <= RST_COLOR_KERNEL;
      color_program_r <= RST_COLOR_PROGRAM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_NORMAL:  color_normal_r  <= cfg_data;
        CFG_COLOR_KERNEL:  color_kernel_r  <= cfg_data;
        CFG_COLOR_PROGRAM: color_program_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tcw_back.sv
`timescale 1ns / 1ps
module tcw_back #(
  parameter int SCREEN_COLS = 80,
  parameter int LAST_ROW    = 24,
  parameter int AW          = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  tcw_pkg::cmd_ctl_t           q_ctl,
  input  logic [AW-1:0]               q_addr,
  input  logic [tcw_pkg::CELL_W-1:0]  q_data,
  input  logic [tcw_pkg::POS_W-1:0]   q_pos,
  output logic                        q_pop,
  input  logic                        out_pop,
  output logic                        out_empty,
  output logic [tcw_pkg::POS_W-1:0]   out_cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0]  out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]  out_cell_attr,
  output logic                        init_busy
);
  import tcw_pkg::*;

  localparam int CELLS  = SCREEN_COLS * (LAST_ROW + 1);
  localparam int MOVE_N = SCREEN_COLS * LAST_ROW;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] mem_rd_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [CELL_W-1:0] mem_wd;

  back_state_t       st_r, st_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     wa_r;
  logic              emit_r, emit_nxt;
  logic [POS_W-1:0]  hold_pos_r, hold_pos_nxt;
  logic [ATTR_W-1:0] fill_attr_r, fill_attr_nxt;

  logic              res_valid_r;
  logic              res_set, slot_free;
  logic [POS_W-1:0]  res_pos;
  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;

  assign slot_free = !res_valid_r || out_pop;
  assign init_busy = (st_r == BK_CLEAR) && !emit_r;
  assign out_empty = !res_valid_r;

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    emit_nxt      = emit_r;
    hold_pos_nxt  = hold_pos_r;
    fill_attr_nxt = fill_attr_r;
    mem_we        = 1'b0;
    mem_wa        = q_addr;
    mem_wd        = q_data;
    mem_ra        = q_addr;
    q_pop         = 1'b0;
    res_set       = 1'b0;
    res_pos       = hold_pos_r;
    res_char      = '0;
    res_attr      = '0;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop         = 1'b1;
          hold_pos_nxt  = q_pos;
          fill_attr_nxt = q_data[CELL_W-1:CHAR_W];
          cnt_nxt       = '0;
          mem_we        = q_ctl.wr;
          priority if (q_ctl.clr) begin
            st_nxt   = BK_CLEAR;
            emit_nxt = 1'b1;
          end else if (q_ctl.scroll) begin
            st_nxt = BK_SCROLL;
          end else if (q_ctl.rd) begin
            st_nxt = BK_READ;
          end else begin
            res_set = 1'b1;
            res_pos = q_pos;
          end
        end
      end
      BK_READ: begin
        res_set  = 1'b1;
        res_char = mem_rd_r[CHAR_W-1:0];
        res_attr = mem_rd_r[CELL_W-1:CHAR_W];
        st_nxt   = BK_IDLE;
      end
      BK_SCROLL: begin
        // read one row down, write it back in the following cycle
        mem_ra = (cnt_r < AW'(MOVE_N)) ? cnt_r + AW'(SCREEN_COLS) : '0;
        mem_we = (cnt_r != '0);
        mem_wa = wa_r;
        mem_wd = mem_rd_r;
        if (cnt_r == AW'(MOVE_N)) begin
          cnt_nxt = '0;
          st_nxt  = BK_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      BK_FILL: begin
        mem_we = 1'b1;
        mem_wa = AW'(MOVE_N) + cnt_r;
        mem_wd = {fill_attr_r, CH_SPACE};
        if (cnt_r == AW'(SCREEN_COLS - 1)) begin
          res_set = 1'b1;
          st_nxt  = BK_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        mem_wd = '0;
        if (cnt_r == AW'(CELLS - 1)) begin
          res_set = emit_r;
          cnt_nxt = '0;
          st_nxt  = BK_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_CLEAR;
      cnt_r       <= '0;
      emit_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      emit_r <= emit_nxt;
      if (res_set) begin
        res_valid_r <= 1'b1;
      end else if (out_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa_r        <= cnt_r;
    hold_pos_r  <= hold_pos_nxt;
    fill_attr_r <= fill_attr_nxt;
    if (res_set) begin
      out_cursor_pos <= res_pos;
      out_cell_char  <= res_char;
      out_cell_attr  <= res_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    mem_rd_r <= mem[mem_ra];
  end

endmodule

// File: rtl/tcw_checker.sv
`timescale 1ns / 1ps
`include "text_console_char_writer_top_defines.svh"
module tcw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_full,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic [tcw_pkg::POS_W-1:0]      out_cursor_pos,
  input logic [tcw_pkg::CHAR_W-1:0]     out_cell_char,
  input logic [tcw_pkg::ATTR_W-1:0]     out_cell_attr
);

  // reset leaves no result and starts the clearing sweep
  `TCW_ASSERT(a_reset_quiet, !rst_n |=> out_empty && in_full,
              "result or intake live after reset")

  // sweep still running in the first cycle out of reset
  `TCW_ASSERT(a_init_blocks, $rose(rst_n) |-> in_full && out_empty,
              "request taken during clearing sweep")

  // a waiting result holds until popped
  `TCW_ASSERT_RST(a_result_holds,
                  !out_empty && !out_pop |=> !out_empty && $stable(out_cursor_pos) &&
                  $stable(out_cell_char) && $stable(out_cell_attr),
                  "waiting result changed")

endmodule

bind text_console_char_writer_top tcw_checker u_chk (.*);

// File: verif/tb_text_console_char_writer_top.sv
`timescale 1ns / 1ps
module tb_text_console_char_writer_top;
  import tcw_pkg::*;

  localparam int SCREEN_COLS = DEF_SCREEN_COLS;
  localparam int LAST_ROW = DEF_LAST_ROW;
  localparam int TAB_WIDTH = DEF_TAB_WIDTH;
  localparam int CELL_COUNT = SCREEN_COLS * (LAST_ROW + 1);
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = CELL_COUNT + 2 * SCREEN_COLS + 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQUESTS = 50;

  localparam logic [SEL_W-1:0] SEL_NORMAL = 2'd0;
  localparam logic [SEL_W-1:0] SEL_SPARE = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } cursor_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [OP_W-1:0] in_op = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [SEL_W-1:0] in_attr_select = '0;
  logic [TCOL_W-1:0] in_target_col = '0;
  logic [TROW_W-1:0] in_target_row = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [POS_W-1:0] out_cursor_pos;
  logic [CHAR_W-1:0] out_cell_char;
  logic [ATTR_W-1:0] out_cell_attr;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ATTR_W-1:0] cfg_data = '0;

  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int cur_col;
  int cur_row;
  logic [ATTR_W-1:0] colour_normal;
  logic [ATTR_W-1:0] colour_kernel;
  logic [ATTR_W-1:0] colour_program;

  cursor_report_t pending_reports [$];
  cursor_report_t want;
  int fail_count = 0;
  int idle_cycles = 0;
  int pop_gap_left = 0;
  int result_hold_left = 0;
  bit steady = 1'b0;

  always #5ns clk = ~clk;

  text_console_char_writer_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_char_code  (in_char_code),
    .in_attr_select(in_attr_select),
    .in_target_col (in_target_col),
    .in_target_row (in_target_row),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_cursor_pos(out_cursor_pos),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void wipe_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = '0;
    cur_col = 0;
    cur_row = 0;
  endfunction

  function automatic void advance_line(logic [ATTR_W-1:0] attr);
    cur_col = 0;
    if (cur_row < LAST_ROW) begin
      cur_row++;
    end else begin
      for (int i = 0; i < SCREEN_COLS * LAST_ROW; i++)
        screen_model[i] = screen_model[i + SCREEN_COLS];
      for (int i = 0; i < SCREEN_COLS; i++)
        screen_model[SCREEN_COLS * LAST_ROW + i] = {attr, CH_SPACE};
    end
  endfunction

  function automatic cursor_report_t apply_console_request(
    op_t op, logic [CHAR_W-1:0] ch, logic [SEL_W-1:0] sel,
    logic [TCOL_W-1:0] tcol, logic [TROW_W-1:0] trow);
    cursor_report_t r;
    logic [ATTR_W-1:0] attr;
    logic [CELL_W-1:0] cell_word;
    int col_c;
    int row_c;
    r = '0;
    col_c = (int'(tcol) > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : int'(tcol);
    row_c = (int'(trow) > LAST_ROW) ? LAST_ROW : int'(trow);
    case (sel)
      SEL_KERNEL: attr = colour_kernel;
      SEL_PROGRAM: attr = colour_program;
      default: attr = colour_normal;
    endcase
    case (op)
      OP_PRINT: begin
        case (ch)
          CH_TAB: cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
          CH_CR: cur_col = 0;
          CH_LF: ;
          CH_BS: begin
            if (cur_col > 0) begin
              cur_col--;
              screen_model[cur_row * SCREEN_COLS + cur_col] = {attr, CH_SPACE};
            end
          end
          default: begin
            screen_model[cur_row * SCREEN_COLS + cur_col] = {attr, ch};
            cur_col++;
          end
        endcase
        if (cur_col >= SCREEN_COLS || ch == CH_LF) advance_line(attr);
      end
      OP_CLEAR: wipe_screen();
      OP_MOVE: begin
        cur_col = col_c;
        cur_row = row_c;
      end
      default: begin
        cell_word = screen_model[row_c * SCREEN_COLS + col_c];
        r.ch = cell_word[CHAR_W-1:0];
        r.attr = cell_word[CELL_W-1:CHAR_W];
      end
    endcase
    r.pos = POS_W'(cur_row * SCREEN_COLS + cur_col);
    return r;
  endfunction

  task automatic send_request(op_t op, logic [CHAR_W-1:0] ch, logic [SEL_W-1:0] sel,
                              logic [TCOL_W-1:0] tcol, logic [TROW_W-1:0] trow);
    int gap;
    in_push <= 1'b1;
    in_op <= op;
    in_char_code <= ch;
    in_attr_select <= sel;
    in_target_col <= tcol;
    in_target_row <= trow;
    do @(posedge clk); while (in_full !== 1'b0);
    pending_reports.push_back(apply_console_request(op, ch, sel, tcol, trow));
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic program_colours(logic [ATTR_W-1:0] normal_v, logic [ATTR_W-1:0] kernel_v,
                                 logic [ATTR_W-1:0] program_v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_COLOR_NORMAL;
    cfg_data <= normal_v;
    @(posedge clk);
    cfg_index <= CFG_COLOR_KERNEL;
    cfg_data <= kernel_v;
    @(posedge clk);
    cfg_index <= CFG_COLOR_PROGRAM;
    cfg_data <= program_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    colour_normal = normal_v;
    colour_kernel = kernel_v;
    colour_program = program_v;
  endtask

  task automatic test_reset_state();
    send_request(OP_READ, 8'h00, SEL_NORMAL, 7'd0, 5'd0);
  endtask

  task automatic test_print_colours();
    send_request(OP_PRINT, 8'hFF, SEL_NORMAL, 7'd0, 5'd0);
    send_request(OP_PRINT, 8'h00, SEL_KERNEL, 7'd0, 5'd0);
    send_request(OP_PRINT, 8'h80, SEL_PROGRAM, 7'd0, 5'd0);
    send_request(OP_PRINT, 8'h5A, SEL_SPARE, 7'd0, 5'd0);
    send_request(OP_READ, 8'h00, SEL_NORMAL, 7'd3, 5'd0);
    send_request(OP_READ, 8'h00, SEL_NORMAL, 7'd1, 5'd0);
  endtask

  task automatic test_control_chars();
    send_request(OP_PRINT, CH_CR, SEL_NORMAL, 7'd0, 5'd0);
    send_request(OP_PRINT, CH_BS, SEL_KERNEL, 7'd0, 5'd0);
    send_request(OP_PRINT, CH_TAB, SEL_NORMAL, 7'd0, 5'd0);
    send_request(OP_PRINT, CH_BS, SEL_PROGRAM, 7'd0, 5'd0);
    send_request(OP_PRINT, CH_LF, SEL_NORMAL, 7'd0, 5'd0);
  endtask

  task automatic test_edges_and_scroll();
    send_request(OP_MOVE, 8'h00, SEL_NORMAL, 7'h7F, 5'h1F);
    send_request(OP_PRINT, 8'h78, SEL_KERNEL, 7'd0, 5'd0);
    send_request(OP_MOVE, 8'h00, SEL_NORMAL, 7'd79, 5'd3);
    send_request(OP_PRINT, CH_TAB, SEL_NORMAL, 7'd0, 5'd0);
    send_request(OP_MOVE, 8'h00, SEL_NORMAL, 7'd5, 5'd24);
    send_request(OP_PRINT, CH_LF, SEL_PROGRAM, 7'd0, 5'd0);
    send_request(OP_READ, 8'h00, SEL_NORMAL, 7'h7F, 5'h1F);
  endtask

  task automatic test_clear();
    send_request(OP_CLEAR, 8'h00, SEL_NORMAL, 7'd0, 5'd0);
    send_request(OP_READ, 8'h00, SEL_NORMAL, 7'd0, 5'd0);
    send_request(OP_READ, 8'h00, SEL_NORMAL, 7'd79, 5'd24);
  endtask

  task automatic test_result_backpressure();
    wait_drained();
    steady = 1'b1;
    result_hold_left = 300;
    for (int i = 0; i < 16; i++)
      send_request(OP_PRINT, 8'($urandom_range(8'h21, 8'h7E)), 2'($urandom_range(0, 3)),
                   7'($urandom), 5'($urandom));
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    op_t op;
    logic [CHAR_W-1:0] ch;
    int r;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      if (phase == 0) program_colours(8'h00, 8'h00, 8'h00);
      else if (phase == 1) program_colours(8'hFF, 8'hFF, 8'hFF);
      else program_colours(8'($urandom), 8'($urandom), 8'($urandom));
      steady = (phase == 3 || phase == 6);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70) op = OP_PRINT;
        else if (r < 82) op = OP_READ;
        else if (r < 97) op = OP_MOVE;
        else op = OP_CLEAR;
        ch = 8'($urandom);
        if (op == OP_PRINT && $urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: ch = CH_TAB;
            1: ch = CH_CR;
            2: ch = CH_LF;
            default: ch = CH_BS;
          endcase
        end
        send_request(op, ch, 2'($urandom_range(0, 3)),
                     7'(($urandom_range(0, 4) == 0) ? $urandom_range(80, 127)
                                                    : $urandom_range(0, 79)),
                     5'(($urandom_range(0, 4) == 0) ? $urandom_range(25, 31)
                                                    : $urandom_range(0, 24)));
      end
    end
    steady = 1'b0;
  endtask

  // result side: check each popped report, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: cursor_pos %0d", out_cursor_pos);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_cursor_pos !== want.pos) begin
          $error("cursor_pos: expected %0d, got %0d", want.pos, out_cursor_pos);
          fail_count++;
        end
        if (out_cell_char !== want.ch) begin
          $error("cell_char: expected %0h, got %0h", want.ch, out_cell_char);
          fail_count++;
        end
        if (out_cell_attr !== want.attr) begin
          $error("cell_attr: expected %0h, got %0h", want.attr, out_cell_attr);
          fail_count++;
        end
      end
      pop_gap_left = pick_gap();
    end
    if (result_hold_left > 0) begin
      result_hold_left--;
      out_pop <= 1'b0;
    end else if (pop_gap_left > 0) begin
      pop_gap_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_push && in_full === 1'b0) || (out_pop && out_empty === 1'b0))) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin
    colour_normal = RST_COLOR_NORMAL;
    colour_kernel = RST_COLOR_KERNEL;
    colour_program = RST_COLOR_PROGRAM;
    wipe_screen();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_print_colours();
    test_control_chars();
    test_edges_and_scroll();
    test_clear();
    test_result_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
